// ----- rtl/core/tpi_pkg.sv -----
`timescale 1ns / 1ps

package tpi_pkg;

  localparam int NW        = 18;          // normal component, Q1.16 signed
  localparam int DISTW     = 32;          // face distance, Q16.16 unsigned
  localparam int PLANEW    = 3 * NW + DISTW;
  localparam int IN_W      = 3 * PLANEW;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int COORDW    = 40;          // Q24.16 signed
  localparam int OUT_W     = 1 + 2 + 3 * COORDW;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int CFGW      = 17;

  localparam int PRODW     = 2 * NW;      // normal by normal product
  localparam int DOTW      = PRODW + 2;   // sum of three products
  localparam int CRSW      = PRODW + 1;   // cross product component
  localparam int DETPW     = NW + CRSW;   // normal by cross component
  localparam int DETW      = DETPW + 2;
  localparam int NUMPW     = DISTW + 1 + CRSW;
  localparam int NUMW      = NUMPW + 2;
  localparam int TW        = NUMW + 16;   // scaled and rounded numerator
  localparam int DW        = DETW + 1;    // divisor is twice |D|
  localparam int QW        = COORDW + 1;  // quotient bits before clamping

  localparam int NFRONT    = 6;
  localparam int NSTAGE    = NFRONT + QW + 2;

  localparam logic [1:0] RSN_OK   = 2'd0;
  localparam logic [1:0] RSN_PAR  = 2'd1;
  localparam logic [1:0] RSN_SING = 2'd2;
  localparam logic [1:0] RSN_SAT  = 2'd3;

  localparam logic CFG_PAR_LIMIT = 1'b0;
  localparam logic CFG_DET_LIMIT = 1'b1;

  localparam logic [CFGW-1:0] PAR_LIMIT_RST = 17'd65535;
  localparam logic [CFGW-1:0] DET_LIMIT_RST = 17'd7;

  localparam logic [QW-1:0] POS_LIM = QW'((41'd1 << (COORDW - 1)) - 41'd1);
  localparam logic [QW-1:0] NEG_LIM = QW'(41'd1 << (COORDW - 1));

endpackage

// ----- rtl/core/three_plane_intersection.sv -----
`timescale 1ns / 1ps

// Intersects three planes (unit normal Q1.16, face distance Q16.16, right-hand
// side half the distance) by Cramer's rule and returns one point per transfer
// in Q24.16. The datapath is a 49-stage pipeline: six stages of products,
// sums, magnitudes and scaling, then a restoring divider with one setup stage
// and one quotient bit per stage for 41 stages, then the output register. One
// plane triple is accepted every cycle while the output side takes results.
// Nearly parallel normals give reason 1, a small determinant reason 2, both
// with zero coordinates; a clamped coordinate keeps the point valid with
// reason 3.
module three_plane_intersection (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_idx,
  input  logic [tpi_pkg::CFGW-1:0]          cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // p0_nx, p0_ny, p0_nz, p0_dist, p1_nx, p1_ny, p1_nz, p1_dist,
  // p2_nx, p2_ny, p2_nz, p2_dist
  input  logic [tpi_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // point_valid, fail_reason, point_x, point_y, point_z
  output logic [tpi_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int NW = tpi_pkg::NW;
  localparam int QW = tpi_pkg::QW;
  localparam int DW = tpi_pkg::DW;
  localparam int LAST = tpi_pkg::NSTAGE - 1;

  logic [tpi_pkg::CFGW-1:0] par_lim_r, det_lim_r;
  logic [tpi_pkg::NSTAGE-1:0] vld_r;
  logic en;

  logic signed [NW-1:0] n_in [3][3];
  logic [tpi_pkg::DISTW-1:0] d_in [3];

  // stage 1
  logic signed [tpi_pkg::PRODW-1:0] s1_pd_r [3][3];
  logic signed [tpi_pkg::PRODW-1:0] s1_pc_r [3][3][2];
  logic signed [NW-1:0] s1_n0_r [3];
  logic [tpi_pkg::DISTW-1:0] s1_d_r [3];
  // stage 2
  logic signed [tpi_pkg::DOTW-1:0] s2_dot_r [3];
  logic signed [tpi_pkg::CRSW-1:0] s2_c_r [3][3];
  logic signed [NW-1:0] s2_n0_r [3];
  logic [tpi_pkg::DISTW-1:0] s2_d_r [3];
  // stage 3
  logic signed [tpi_pkg::DETPW-1:0] s3_dp_r [3];
  logic signed [tpi_pkg::NUMPW-1:0] s3_np_r [3][3];
  logic s3_par_r;
  // stage 4
  logic signed [tpi_pkg::DETW-1:0] s4_det_r;
  logic signed [tpi_pkg::NUMW-1:0] s4_num_r [3];
  logic s4_par_r;
  // stage 5
  logic [tpi_pkg::DETW-1:0] s5_dmag_r;
  logic [tpi_pkg::NUMW-1:0] s5_mag_r [3];
  logic s5_neg_r [3];
  logic [1:0] s5_rsn_r;
  // stage 6
  logic [tpi_pkg::TW-1:0] s6_t_r [3];
  logic [DW-1:0] s6_div_r;
  logic s6_neg_r [3];
  logic [1:0] s6_rsn_r;
  // divider stages
  logic [DW-1:0] dv_rem_r [QW+1][3];
  logic [QW-1:0] dv_quo_r [QW+1][3];
  logic [QW-1:0] dv_low_r [QW+1][3];
  logic dv_ovf_r [QW+1][3];
  logic dv_neg_r [QW+1][3];
  logic [DW-1:0] dv_div_r [QW+1];
  logic [1:0] dv_rsn_r [QW+1];

  logic [tpi_pkg::OUT_TDATA_W-1:0] out_r;

  assign en = !vld_r[LAST] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAST];
  assign out_tdata = out_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        n_in[k][i] = in_tdata[k * tpi_pkg::PLANEW + i * NW +: NW];
      end
      d_in[k] = in_tdata[k * tpi_pkg::PLANEW + 3 * NW +: tpi_pkg::DISTW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_lim_r <= tpi_pkg::PAR_LIMIT_RST;
      det_lim_r <= tpi_pkg::DET_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_idx == tpi_pkg::CFG_PAR_LIMIT) begin
        par_lim_r <= cfg_wdata;
      end else begin
        det_lim_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_tvalid};
    end
  end

  // Front end: products, sums, magnitudes and the scaled numerator.
  always_ff @(posedge clk) begin
    logic par;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_n0_r[k] <= n_in[0][k];
        s1_d_r[k]  <= d_in[k];
        s1_pd_r[0][k] <= tpi_pkg::PRODW'(n_in[0][k]) * tpi_pkg::PRODW'(n_in[1][k]);
        s1_pd_r[1][k] <= tpi_pkg::PRODW'(n_in[0][k]) * tpi_pkg::PRODW'(n_in[2][k]);
        s1_pd_r[2][k] <= tpi_pkg::PRODW'(n_in[1][k]) * tpi_pkg::PRODW'(n_in[2][k]);
        for (int i = 0; i < 3; i++) begin
          // C_k = n[k+1] x n[k+2]
          s1_pc_r[k][i][0] <= tpi_pkg::PRODW'(n_in[(k + 1) % 3][(i + 1) % 3])
                              * tpi_pkg::PRODW'(n_in[(k + 2) % 3][(i + 2) % 3]);
          s1_pc_r[k][i][1] <= tpi_pkg::PRODW'(n_in[(k + 1) % 3][(i + 2) % 3])
                              * tpi_pkg::PRODW'(n_in[(k + 2) % 3][(i + 1) % 3]);
        end
      end

      for (int k = 0; k < 3; k++) begin
        s2_n0_r[k] <= s1_n0_r[k];
        s2_d_r[k]  <= s1_d_r[k];
        s2_dot_r[k] <= tpi_pkg::DOTW'(s1_pd_r[k][0]) + tpi_pkg::DOTW'(s1_pd_r[k][1])
                       + tpi_pkg::DOTW'(s1_pd_r[k][2]);
        for (int i = 0; i < 3; i++) begin
          s2_c_r[k][i] <= tpi_pkg::CRSW'(s1_pc_r[k][i][0]) - tpi_pkg::CRSW'(s1_pc_r[k][i][1]);
        end
      end

      par = 1'b0;
      for (int k = 0; k < 3; k++) begin
        s3_dp_r[k] <= tpi_pkg::DETPW'(s2_n0_r[k]) * tpi_pkg::DETPW'(s2_c_r[0][k]);
        for (int i = 0; i < 3; i++) begin
          s3_np_r[k][i] <= tpi_pkg::NUMPW'($signed({1'b0, s2_d_r[k]}))
                           * tpi_pkg::NUMPW'(s2_c_r[k][i]);
        end
        if ((s2_dot_r[k] < 0 ? tpi_pkg::DOTW'(-s2_dot_r[k]) : tpi_pkg::DOTW'(s2_dot_r[k]))
            > tpi_pkg::DOTW'({par_lim_r, 16'd0})) begin
          par = 1'b1;
        end
      end
      s3_par_r <= par;

      s4_par_r <= s3_par_r;
      s4_det_r <= tpi_pkg::DETW'(s3_dp_r[0]) + tpi_pkg::DETW'(s3_dp_r[1])
                  + tpi_pkg::DETW'(s3_dp_r[2]);
      for (int i = 0; i < 3; i++) begin
        s4_num_r[i] <= tpi_pkg::NUMW'(s3_np_r[0][i]) + tpi_pkg::NUMW'(s3_np_r[1][i])
                       + tpi_pkg::NUMW'(s3_np_r[2][i]);
      end

      s5_dmag_r <= s4_det_r < 0 ? tpi_pkg::DETW'(-s4_det_r) : tpi_pkg::DETW'(s4_det_r);
      if (s4_par_r) begin
        s5_rsn_r <= tpi_pkg::RSN_PAR;
      end else if (s4_det_r == 0 || (s4_det_r < 0 ? tpi_pkg::DETW'(-s4_det_r)
                   : tpi_pkg::DETW'(s4_det_r)) < tpi_pkg::DETW'({det_lim_r, 32'd0})) begin
        s5_rsn_r <= tpi_pkg::RSN_SING;
      end else begin
        s5_rsn_r <= tpi_pkg::RSN_OK;
      end
      for (int i = 0; i < 3; i++) begin
        s5_neg_r[i] <= s4_num_r[i] < 0;
        s5_mag_r[i] <= s4_num_r[i] < 0 ? tpi_pkg::NUMW'(-s4_num_r[i])
                       : tpi_pkg::NUMW'(s4_num_r[i]);
      end

      // Adding |D| before dividing by 2|D| rounds half away from zero.
      s6_rsn_r <= s5_rsn_r;
      s6_div_r <= {s5_dmag_r, 1'b0};
      for (int i = 0; i < 3; i++) begin
        s6_neg_r[i] <= s5_neg_r[i];
        s6_t_r[i] <= {s5_mag_r[i], 16'd0} + tpi_pkg::TW'(s5_dmag_r);
      end

      dv_div_r[0] <= s6_div_r;
      dv_rsn_r[0] <= s6_rsn_r;
      for (int i = 0; i < 3; i++) begin
        dv_neg_r[0][i] <= s6_neg_r[i];
        dv_ovf_r[0][i] <= DW'(s6_t_r[i][tpi_pkg::TW-1:QW]) >= s6_div_r;
        dv_rem_r[0][i] <= DW'(s6_t_r[i][tpi_pkg::TW-1:QW]);
        dv_low_r[0][i] <= s6_t_r[i][QW-1:0];
        dv_quo_r[0][i] <= '0;
      end
    end
  end

  // Restoring divider, one quotient bit per stage; the partial remainder
  // stays below the divisor unless the overflow flag is set.
  always_ff @(posedge clk) begin
    logic [DW:0] r2;
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        dv_div_r[j + 1] <= dv_div_r[j];
        dv_rsn_r[j + 1] <= dv_rsn_r[j];
        for (int i = 0; i < 3; i++) begin
          r2 = {dv_rem_r[j][i], dv_low_r[j][i][QW-1]};
          dv_neg_r[j + 1][i] <= dv_neg_r[j][i];
          dv_ovf_r[j + 1][i] <= dv_ovf_r[j][i];
          dv_low_r[j + 1][i] <= {dv_low_r[j][i][QW-2:0], 1'b0};
          if (r2 >= {1'b0, dv_div_r[j]}) begin
            dv_rem_r[j + 1][i] <= DW'(r2 - {1'b0, dv_div_r[j]});
            dv_quo_r[j + 1][i] <= {dv_quo_r[j][i][QW-2:0], 1'b1};
          end else begin
            dv_rem_r[j + 1][i] <= DW'(r2);
            dv_quo_r[j + 1][i] <= {dv_quo_r[j][i][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Clamp, sign and pack.
  always_ff @(posedge clk) begin
    logic [QW-1:0] lim, q;
    logic sat;
    logic [tpi_pkg::COORDW-1:0] pt [3];
    if (en) begin
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        lim = dv_neg_r[QW][i] ? tpi_pkg::NEG_LIM : tpi_pkg::POS_LIM;
        q = dv_quo_r[QW][i];
        if (dv_ovf_r[QW][i] || q > lim) begin
          q = lim;
          sat = 1'b1;
        end
        pt[i] = dv_neg_r[QW][i] ? tpi_pkg::COORDW'(-q) : q[tpi_pkg::COORDW-1:0];
      end
      if (dv_rsn_r[QW] == tpi_pkg::RSN_OK) begin
        out_r <= tpi_pkg::OUT_TDATA_W'({pt[2], pt[1], pt[0],
                                        sat ? tpi_pkg::RSN_SAT : tpi_pkg::RSN_OK, 1'b1});
      end else begin
        out_r <= tpi_pkg::OUT_TDATA_W'({dv_rsn_r[QW], 1'b0});
      end
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[tpi_pkg::OUT_W-1:3] == '0)
    else $error("invalid point carries nonzero coordinates");

  a_reason_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0] == (out_tdata[2:1] == tpi_pkg::RSN_OK
                                    || out_tdata[2:1] == tpi_pkg::RSN_SAT))
    else $error("fail reason disagrees with point_valid");

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline is stalled");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int NW          = tpi_pkg::NW;
  localparam int DISTW       = tpi_pkg::DISTW;
  localparam int PLANEW      = tpi_pkg::PLANEW;
  localparam int COORDW      = tpi_pkg::COORDW;
  localparam int CFGW        = tpi_pkg::CFGW;
  localparam int IN_TDATA_W  = tpi_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = tpi_pkg::OUT_TDATA_W;

  typedef struct packed {
    logic signed [NW-1:0] nx, ny, nz;
    logic [DISTW-1:0]     fdist;
  } plane_t;

  typedef struct {
    logic                     ok;
    logic [1:0]               reason;
    logic signed [COORDW-1:0] x, y, z;
  } point_t;

  typedef struct {
    plane_t p0, p1, p2;
    logic   has_exp;
    logic   e_ok;
    logic [1:0] e_reason;
  } stim_row_t;

  logic clk, rst_n;
  logic cfg_we, cfg_idx;
  logic [CFGW-1:0] cfg_wdata;
  logic in_tvalid, in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [CFGW-1:0] par_limit, det_limit;
  point_t pending_points[$];
  int n_fail = 0;
  logic hold_off;
  logic hold_req;
  logic no_idle;

  three_plane_intersection u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  function automatic logic signed [63:0] dot3(plane_t a, plane_t b);
    return 64'(a.nx) * 64'(b.nx) + 64'(a.ny) * 64'(b.ny) + 64'(a.nz) * 64'(b.nz);
  endfunction

  // Field order on the bus: nx lowest, then ny, nz and the distance.
  function automatic logic [PLANEW-1:0] pack_plane(plane_t p);
    return {p.fdist, p.nz, p.ny, p.nx};
  endfunction

  // Solves the three plane equations exactly; wide integers keep it bit true.
  function automatic point_t solve_planes(plane_t p0, plane_t p1, plane_t p2);
    point_t r;
    logic signed [63:0] n[3][3], c[3][3], det, dmag;
    logic [31:0] d[3];
    logic signed [63:0] pl;
    logic signed [159:0] num, mag, q;
    logic neg;
    plane_t pp[3];
    r.ok = 1'b0; r.reason = tpi_pkg::RSN_OK; r.x = '0; r.y = '0; r.z = '0;
    pp[0] = p0; pp[1] = p1; pp[2] = p2;
    for (int k = 0; k < 3; k++) begin
      n[k][0] = 64'(pp[k].nx); n[k][1] = 64'(pp[k].ny); n[k][2] = 64'(pp[k].nz);
      d[k] = pp[k].fdist;
    end
    pl = 64'(par_limit) << 16;
    if ((dot3(p0, p1) > pl) || (-dot3(p0, p1) > pl) || (dot3(p0, p2) > pl) ||
        (-dot3(p0, p2) > pl) || (dot3(p1, p2) > pl) || (-dot3(p1, p2) > pl)) begin
      r.reason = tpi_pkg::RSN_PAR;
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      int a, b;
      a = (k + 1) % 3; b = (k + 2) % 3;
      c[k][0] = n[a][1] * n[b][2] - n[a][2] * n[b][1];
      c[k][1] = n[a][2] * n[b][0] - n[a][0] * n[b][2];
      c[k][2] = n[a][0] * n[b][1] - n[a][1] * n[b][0];
    end
    det = n[0][0] * c[0][0] + n[0][1] * c[0][1] + n[0][2] * c[0][2];
    dmag = det < 0 ? -det : det;
    if (dmag == 0 || dmag < (64'(det_limit) << 32)) begin
      r.reason = tpi_pkg::RSN_SING;
      return r;
    end
    r.ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      num = 160'(signed'({1'b0, d[0]})) * 160'(c[0][i])
          + 160'(signed'({1'b0, d[1]})) * 160'(c[1][i])
          + 160'(signed'({1'b0, d[2]})) * 160'(c[2][i]);
      neg = num < 0;
      mag = neg ? -num : num;
      q = ((mag <<< 16) + 160'(dmag)) / (160'(dmag) <<< 1);
      if (!neg && q > 160'(tpi_pkg::POS_LIM)) begin
        q = 160'(tpi_pkg::POS_LIM); r.reason = tpi_pkg::RSN_SAT;
      end
      if (neg && q > 160'(tpi_pkg::NEG_LIM)) begin
        q = 160'(tpi_pkg::NEG_LIM); r.reason = tpi_pkg::RSN_SAT;
      end
      if (neg) q = -q;
      if (i == 0) r.x = q[COORDW-1:0];
      else if (i == 1) r.y = q[COORDW-1:0];
      else r.z = q[COORDW-1:0];
    end
    return r;
  endfunction

  function automatic logic [NW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return NW'(65536);
      1: return NW'(-65536);
      2: return NW'($urandom);
      3: return '0;
      default: return NW'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic plane_t rand_plane();
    plane_t p;
    p.nx = rand_comp(); p.ny = rand_comp(); p.nz = rand_comp();
    case ($urandom_range(0, 3))
      0: p.fdist = $urandom;
      1: p.fdist = $urandom_range(0, 32'h000F_FFFF);
      2: p.fdist = 32'hFFFF_FFFF;
      default: p.fdist = $urandom_range(0, 32'h03FF_FFFF);
    endcase
    return p;
  endfunction

  // Nearly orthogonal normals so most triples reach the divider.
  function automatic plane_t axis_plane(int ax);
    plane_t p;
    p.nx = NW'(int'($urandom_range(0, 20000)) - 10000);
    p.ny = NW'(int'($urandom_range(0, 20000)) - 10000);
    p.nz = NW'(int'($urandom_range(0, 20000)) - 10000);
    if (ax == 0) p.nx = $urandom_range(0, 1) ? NW'(65536) : NW'(-65536);
    if (ax == 1) p.ny = $urandom_range(0, 1) ? NW'(60000) : NW'(-60000);
    if (ax == 2) p.nz = $urandom_range(0, 1) ? NW'(65000) : NW'(-65000);
    p.fdist = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
    return p;
  endfunction

  task automatic write_reg(logic idx, logic [CFGW-1:0] val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tpi_pkg::CFG_PAR_LIMIT) par_limit = val; else det_limit = val;
    @(posedge clk);
  endtask

  task automatic drain_pipe();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (tpi_pkg::NSTAGE + 10) @(posedge clk);
  endtask

  task automatic send_triple(plane_t p0, plane_t p1, plane_t p2, point_t want);
    while (!no_idle && $urandom_range(0, 99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({pack_plane(p2), pack_plane(p1), pack_plane(p0)});
    pending_points.insert(pending_points.size(), want);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_checked(plane_t p0, plane_t p1, plane_t p2);
    send_triple(p0, p1, p2, solve_planes(p0, p1, p2));
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      point_t got, want;
      got.ok = out_tdata[0];
      got.reason = out_tdata[2:1];
      got.x = out_tdata[3 +: COORDW];
      got.y = out_tdata[3 + COORDW +: COORDW];
      got.z = out_tdata[3 + 2 * COORDW +: COORDW];
      if (pending_points.size() == 0) begin
        $error("result transfer with nothing pending");
        n_fail++;
      end else begin
        want = pending_points.pop_front();
        if (got.ok !== want.ok) begin
          $error("point_valid exp %0d got %0d", want.ok, got.ok); n_fail++;
        end
        if (got.reason !== want.reason) begin
          $error("fail_reason exp %0d got %0d", want.reason, got.reason); n_fail++;
        end
        if (got.x !== want.x) begin
          $error("point_x exp %0d got %0d", want.x, got.x); n_fail++;
        end
        if (got.y !== want.y) begin
          $error("point_y exp %0d got %0d", want.y, got.y); n_fail++;
        end
        if (got.z !== want.z) begin
          $error("point_z exp %0d got %0d", want.z, got.z); n_fail++;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else if (no_idle) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 99) >= 19);
  end

  initial begin
    int hold_cnt;
    hold_off = 1'b0;
    wait (hold_req);
    hold_off = 1'b1;
    hold_cnt = 0;
    while (hold_cnt < 300) begin
      @(posedge clk);
      hold_cnt++;
    end
    hold_off = 1'b0;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    plane_t ex, ey, ez, zero_p;
    point_t typed;
    hold_req = 1'b0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = tpi_pkg::CFG_PAR_LIMIT; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0;
    par_limit = tpi_pkg::PAR_LIMIT_RST;
    det_limit = tpi_pkg::DET_LIMIT_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    ex = '{NW'(65536), NW'(0), NW'(0), 32'h0002_0000};
    ey = '{NW'(0), NW'(65536), NW'(0), 32'h0004_0000};
    ez = '{NW'(0), NW'(0), NW'(-65536), 32'hFFFF_FFFF};
    zero_p = '0;
    // Parallel pair, zero determinant, unit axes, extreme distances.
    r = '{ex, ex, ez, 1'b1, 1'b0, tpi_pkg::RSN_PAR}; rows.insert(rows.size(), r);
    r = '{ex, ey, zero_p, 1'b1, 1'b0, tpi_pkg::RSN_SING}; rows.insert(rows.size(), r);
    r = '{ex, ey, ez, 1'b0, 1'b0, tpi_pkg::RSN_OK}; rows.insert(rows.size(), r);
    r = '{zero_p, zero_p, zero_p, 1'b1, 1'b0, tpi_pkg::RSN_SING};
    rows.insert(rows.size(), r);
    r = '{'{NW'(-65536), NW'(0), NW'(0), '1}, ey, ez, 1'b0, 1'b0, tpi_pkg::RSN_OK};
    rows.insert(rows.size(), r);
    // Tiny determinant, below the default determinant limit, so reason 2 (singular).
    r = '{'{NW'(1), NW'(0), NW'(0), '1}, '{NW'(0), NW'(1), NW'(0), '1},
          '{NW'(0), NW'(0), NW'(-1), '1}, 1'b0, 1'b0, tpi_pkg::RSN_OK};
    rows.insert(rows.size(), r);
    r = '{'{NW'(131071), NW'(131072), NW'(-1), 32'h0}, ey, ez, 1'b0, 1'b0,
          tpi_pkg::RSN_OK};
    rows.insert(rows.size(), r);
    r = '{'{NW'(40000), NW'(40000), NW'(0), '1}, '{NW'(40000), NW'(-40000), NW'(0), 32'h1},
          ez, 1'b0, 1'b0, tpi_pkg::RSN_OK};
    rows.insert(rows.size(), r);
    for (int i = 0; i < 8; i++) begin
      r = '{rand_plane(), rand_plane(), rand_plane(), 1'b0, 1'b0, tpi_pkg::RSN_OK};
      rows.insert(rows.size(), r);
    end
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        typed.ok = rows[i].e_ok; typed.reason = rows[i].e_reason;
        typed.x = '0; typed.y = '0; typed.z = '0;
        send_triple(rows[i].p0, rows[i].p1, rows[i].p2, typed);
      end else begin
        send_checked(rows[i].p0, rows[i].p1, rows[i].p2);
      end
    end
    in_tvalid <= 1'b0;

    for (int phase = 0; phase < 5; phase++) begin
      drain_pipe();
      case (phase)
        0: begin
          write_reg(tpi_pkg::CFG_PAR_LIMIT, 17'd65536);
          write_reg(tpi_pkg::CFG_DET_LIMIT, 17'd0);
        end
        1: begin
          write_reg(tpi_pkg::CFG_PAR_LIMIT, 17'd0);
          write_reg(tpi_pkg::CFG_DET_LIMIT, 17'd65536);
        end
        2: begin
          write_reg(tpi_pkg::CFG_PAR_LIMIT, 17'd30000);
          write_reg(tpi_pkg::CFG_DET_LIMIT, 17'd1000);
        end
        3: begin
          write_reg(tpi_pkg::CFG_PAR_LIMIT, 17'h1FFFF);
          write_reg(tpi_pkg::CFG_DET_LIMIT, 17'h1FFFF);
        end
        default: begin
          write_reg(tpi_pkg::CFG_PAR_LIMIT, tpi_pkg::PAR_LIMIT_RST);
          write_reg(tpi_pkg::CFG_DET_LIMIT, 17'd1);
        end
      endcase
      no_idle = (phase == 2);
      for (int i = 0; i < 280; i++) begin
        if (phase == 4 && i == 20) hold_req = 1'b1;
        if ($urandom_range(0, 99) < 75)
          send_checked(axis_plane(0), axis_plane(1), axis_plane(2));
        else
          send_checked(rand_plane(), rand_plane(), rand_plane());
      end
      in_tvalid <= 1'b0;
    end
    no_idle = 1'b0;
    drain_pipe();

    if (n_fail == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
